// File: hdl/lss_pkg.sv
// ============================================================================
// lss_pkg
// Shared types and constants for the link session supervisor: event codes,
// link state encoding and the decoded command that moves front to back.
// ============================================================================
package lss_pkg;

    localparam int unsigned ID_W      = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned TIMEOUT_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;

    // Event codes as carried on the action field
    typedef enum logic [2:0] {
        OP_CONNECT    = 3'd0,
        OP_DISCONNECT = 3'd1,
        OP_HEARTBEAT  = 3'd2,
        OP_ROUTE      = 3'd3,
        OP_MARK_LOST  = 3'd4,
        OP_RECOVER    = 3'd5,
        OP_RESTORE    = 3'd6,
        OP_QUERY      = 3'd7
    } op_t;

    // Link state encoding; degraded is encoded but never entered
    typedef enum logic [2:0] {
        ST_DISCONNECTED = 3'd0,
        ST_CONNECTED    = 3'd1,
        ST_DEGRADED     = 3'd2,
        ST_LOST         = 3'd3,
        ST_RECOVERING   = 3'd4
    } link_state_t;

    // Classified request handed from front to back
    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   sys_id;
        logic [ID_W-1:0]   comp_id;
        logic              ident_ok;    // complete identity with v2 and dialect
        logic              restore_ok;  // v2 and dialect, completeness not needed
        logic              msg_ok;      // decodable, supported, right type
        logic [TIME_W-1:0] time_ms;
    } cmd_t;

endpackage

// File: hdl/lss_front.sv
// ============================================================================
// lss_front
// Accepts input requests and classifies them into a command: decodes the
// event code and folds the identity and message flags into pass/fail bits.
// ============================================================================
module lss_front
    import lss_pkg::*;
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        action,
    input  logic [ID_W-1:0]   system_id,
    input  logic [ID_W-1:0]   component_id,
    input  logic              identity_complete,
    input  logic              protocol_v2,
    input  logic              dialect_present,
    input  logic              is_heartbeat,
    input  logic              malformed,
    input  logic              supported,
    input  logic [TIME_W-1:0] time_ms,
    input  logic              queue_full,
    output logic              push,
    output cmd_t              cmd
);

    op_t op;

    // Hold the sender off while the queue has no room
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // Classify the request
    always_comb
    begin
        op = op_t'(action);
        cmd.op         = op;
        cmd.sys_id     = system_id;
        cmd.comp_id    = component_id;
        cmd.ident_ok   = identity_complete && protocol_v2 && dialect_present;
        cmd.restore_ok = protocol_v2 && dialect_present;
        cmd.time_ms    = time_ms;
        case (op)
            OP_HEARTBEAT: cmd.msg_ok = is_heartbeat && !malformed && supported;
            OP_ROUTE:     cmd.msg_ok = !malformed && supported;
            default:      cmd.msg_ok = 1'b0;
        endcase
    end

endmodule

// File: hdl/lss_queue.sv
// ============================================================================
// lss_queue
// Short command queue between front and back so each side stalls on its own.
// Push and pop may happen in the same cycle.
// ============================================================================
module lss_queue
    import lss_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hdl/lss_back.sv
// ============================================================================
// lss_back
// Executes commands against the session state, updates the saturating
// counts and loads the result into the output register.
// ============================================================================
module lss_back
    import lss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [TIMEOUT_W-1:0] cfg_wr_data,
    input  logic                 cmd_avail,
    input  cmd_t                 cmd,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 ok,
    output logic [2:0]           link_state,
    output logic                 heartbeat_fresh,
    output logic [COUNT_W-1:0]   accepted_count,
    output logic [COUNT_W-1:0]   rejected_count
);

    link_state_t          state_reg, state_next;
    logic [ID_W-1:0]      bound_sys_reg, bound_sys_next;
    logic [ID_W-1:0]      bound_comp_reg, bound_comp_next;
    logic [TIME_W-1:0]    beat_time_reg, beat_time_next;
    logic                 beat_valid_reg, beat_valid_next;
    logic [COUNT_W-1:0]   acc_reg, acc_next;
    logic [COUNT_W-1:0]   rej_reg, rej_next;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic                 out_valid_reg;
    logic                 ok_reg, ok_next;
    logic                 fresh_reg, fresh_next;
    link_state_t          out_state_reg;

    logic                 open_sess;
    logic                 src_match;
    logic                 count_acc;
    logic                 count_rej;
    logic [TIME_W-1:0]    age;

    // Take a command when the output register is free or being drained
    assign pop = cmd_avail && (!out_valid_reg || !out_stall);

    assign open_sess = (state_reg == ST_CONNECTED) || (state_reg == ST_RECOVERING);
    assign src_match = (cmd.sys_id == bound_sys_reg) && (cmd.comp_id == bound_comp_reg);

    // Next session state and verdict
    always_comb
    begin
        state_next      = state_reg;
        bound_sys_next  = bound_sys_reg;
        bound_comp_next = bound_comp_reg;
        beat_time_next  = beat_time_reg;
        beat_valid_next = beat_valid_reg;
        ok_next         = 1'b1;
        count_acc       = 1'b0;
        count_rej       = 1'b0;
        case (cmd.op)
            OP_CONNECT:
            begin
                if (cmd.ident_ok)
                begin
                    bound_sys_next  = cmd.sys_id;
                    bound_comp_next = cmd.comp_id;
                    state_next      = ST_CONNECTED;
                    beat_valid_next = 1'b0;
                end
                else
                begin
                    state_next = ST_DISCONNECTED;
                    ok_next    = 1'b0;
                end
            end
            OP_DISCONNECT:
            begin
                state_next      = ST_DISCONNECTED;
                beat_valid_next = 1'b0;
            end
            OP_HEARTBEAT:
            begin
                ok_next = open_sess && cmd.msg_ok && src_match;
                if (ok_next)
                begin
                    beat_time_next  = cmd.time_ms;
                    beat_valid_next = 1'b1;
                    state_next      = ST_CONNECTED;
                    count_acc       = 1'b1;
                end
                else
                begin
                    count_rej = 1'b1;
                end
            end
            OP_ROUTE:
            begin
                ok_next   = open_sess && cmd.msg_ok && src_match;
                count_acc = ok_next;
                count_rej = !ok_next;
            end
            OP_MARK_LOST:
            begin
                if (state_reg inside {ST_CONNECTED, ST_DEGRADED})
                begin
                    state_next = ST_LOST;
                end
            end
            OP_RECOVER:
            begin
                ok_next = (state_reg == ST_LOST);
                if (ok_next)
                begin
                    state_next      = ST_RECOVERING;
                    beat_valid_next = 1'b0;
                end
            end
            OP_RESTORE:
            begin
                ok_next = (state_reg == ST_RECOVERING) && src_match && cmd.restore_ok;
                if (ok_next)
                begin
                    state_next = ST_CONNECTED;
                end
            end
            default:
            begin
                ok_next = 1'b1;
            end
        endcase

        // Saturating counts
        acc_next = acc_reg;
        rej_next = rej_reg;
        if (count_acc && (acc_reg != COUNT_MAX))
        begin
            acc_next = acc_reg + 1'b1;
        end
        if (count_rej && (rej_reg != COUNT_MAX))
        begin
            rej_next = rej_reg + 1'b1;
        end

        // Freshness against the updated heartbeat
        age        = cmd.time_ms - beat_time_next;
        fresh_next = beat_valid_next && (cmd.time_ms >= beat_time_next)
                     && (age <= {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_reg});
    end

    // Session state and timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_DISCONNECTED;
            bound_sys_reg  <= '0;
            bound_comp_reg <= '0;
            beat_time_reg  <= '0;
            beat_valid_reg <= 1'b0;
            acc_reg        <= '0;
            rej_reg        <= '0;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (pop)
            begin
                state_reg      <= state_next;
                bound_sys_reg  <= bound_sys_next;
                bound_comp_reg <= bound_comp_next;
                beat_time_reg  <= beat_time_next;
                beat_valid_reg <= beat_valid_next;
                acc_reg        <= acc_next;
                rej_reg        <= rej_next;
            end
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ok_reg        <= ok_next;
            out_state_reg <= state_next;
            fresh_reg     <= fresh_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign link_state      = out_state_reg;
    assign heartbeat_fresh = fresh_reg;
    assign accepted_count  = acc_reg;
    assign rejected_count  = rej_reg;

endmodule

// File: hdl/link_session_supervisor_top.sv
// Flow: an accepted request is written into the queue, then executed by the back end,
// which loads its result into the output register and raises out_valid.
// Throughput: one request per cycle unless the queue is full or the output stalls;
// the command queue absorbs output stalls up to its depth.
// Reset: asynchronous, active low; link disconnected, ids, heartbeat and counts
// cleared, heartbeat timeout 3000 ms, queue and output register empty.
// ============================================================================
// link_session_supervisor_top
// Telemetry-link session supervisor: front classifies events, a short queue
// decouples it from the back end that runs the session state machine.
// ============================================================================
module link_session_supervisor_top
    import lss_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [TIMEOUT_W-1:0] cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           action,
    input  logic [ID_W-1:0]      system_id,
    input  logic [ID_W-1:0]      component_id,
    input  logic                 identity_complete,
    input  logic                 protocol_v2,
    input  logic                 dialect_present,
    input  logic                 is_heartbeat,
    input  logic                 malformed,
    input  logic                 supported,
    input  logic [TIME_W-1:0]    time_ms,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 ok,
    output logic [2:0]           link_state,
    output logic                 heartbeat_fresh,
    output logic [COUNT_W-1:0]   accepted_count,
    output logic [COUNT_W-1:0]   rejected_count
);

    logic push;
    logic pop;
    logic q_full;
    logic q_not_empty;
    cmd_t front_cmd;
    cmd_t head_cmd;

    lss_front u_front (
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .system_id         (system_id),
        .component_id      (component_id),
        .identity_complete (identity_complete),
        .protocol_v2       (protocol_v2),
        .dialect_present   (dialect_present),
        .is_heartbeat      (is_heartbeat),
        .malformed         (malformed),
        .supported         (supported),
        .time_ms           (time_ms),
        .queue_full        (q_full),
        .push              (push),
        .cmd               (front_cmd)
    );

    lss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    lss_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .cmd_avail       (q_not_empty),
        .cmd             (head_cmd),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .ok              (ok),
        .link_state      (link_state),
        .heartbeat_fresh (heartbeat_fresh),
        .accepted_count  (accepted_count),
        .rejected_count  (rejected_count)
    );

endmodule
